// File: hw/rtl/tgr_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register codes and types of the touch gesture recognizer.
package tgr_pkg;

   // Panel geometry
   localparam int SCREEN_WIDTH = 320;
   localparam int STRIP_TOP    = 200;

   // Field widths
   localparam int X_W        = 9;
   localparam int Y_W        = 8;
   localparam int MS_W       = 32;
   localparam int TIME_W     = 16;
   localparam int PX_W       = 9;
   localparam int REV_W      = 3;
   localparam int RC_W       = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [REV_W-1:0] REV_MAX = REV_W'(7);

   // Register reset values
   localparam logic [TIME_W-1:0] TAP_MAX_MS_RST      = TIME_W'(450);
   localparam logic [TIME_W-1:0] HOLD_MS_RST         = TIME_W'(600);
   localparam logic [PX_W-1:0]   STILL_PX_RST        = PX_W'(20);
   localparam logic [PX_W-1:0]   SWIPE_DOWN_PX_RST   = PX_W'(45);
   localparam logic [PX_W-1:0]   SWIPE_SIDE_PX_RST   = PX_W'(50);
   localparam logic [PX_W-1:0]   SCRUB_STEP_PX_RST   = PX_W'(12);
   localparam logic [REV_W-1:0]  SCRUB_REVERSALS_RST = REV_W'(3);
   localparam logic [RC_W-1:0]   RELEASE_POLLS_RST   = RC_W'(1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TAP_MAX_MS      = 3'd0,
      CSR_HOLD_MS         = 3'd1,
      CSR_STILL_PX        = 3'd2,
      CSR_SWIPE_DOWN_PX   = 3'd3,
      CSR_SWIPE_SIDE_PX   = 3'd4,
      CSR_SCRUB_STEP_PX   = 3'd5,
      CSR_SCRUB_REVERSALS = 3'd6,
      CSR_RELEASE_POLLS   = 3'd7
   } tgr_csr_idx_type;

   typedef enum logic [1:0] {
      DIR_NONE  = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_LEFT  = 2'd2
   } tgr_dir_type;

   typedef struct packed {
      logic [TIME_W-1:0] tap_max_ms;
      logic [TIME_W-1:0] hold_ms;
      logic [PX_W-1:0]   still_px;
      logic [PX_W-1:0]   swipe_down_px;
      logic [PX_W-1:0]   swipe_side_px;
      logic [PX_W-1:0]   scrub_step_px;
      logic [REV_W-1:0]  scrub_reversals;
      logic [RC_W-1:0]   release_polls;
   } tgr_cfg_type;

   typedef struct packed {
      logic           touched;
      logic [X_W-1:0] pos_x;
      logic [Y_W-1:0] pos_y;
      logic [MS_W-1:0] now_ms;
      logic           front_touched;
      logic           mid_touched;
      logic           back_touched;
   } tgr_poll_type;

   // Debounced panel contact with the kept coordinates
   typedef struct packed {
      logic           down;
      logic [X_W-1:0] good_x;
      logic [Y_W-1:0] good_y;
   } tgr_touch_type;

   typedef struct packed {
      logic tap;
      logic hold_start;
      logic hold_end;
   } tgr_body_ev_type;

   typedef struct packed {
      logic tap;
      logic tap_from_body;
      logic scrub;
      logic hold_start;
      logic hold_end;
      logic swipe_down;
      logic swipe_left;
      logic swipe_right;
      logic cancel_buttons;
   } tgr_panel_ev_type;

   typedef struct packed {
      logic tap;
      logic tap_from_body;
      logic scrub;
      logic hold_start;
      logic hold_end;
      logic swipe_down;
      logic swipe_left;
      logic swipe_right;
      logic cancel_buttons;
      logic button_a;
      logic button_b;
   } tgr_result_type;

endpackage

// File: hw/rtl/tgr_if.sv
`timescale 1ns / 1ps
// Request, response and register-write channel interfaces.
interface tgr_req_if;
   import tgr_pkg::*;
   logic            valid;
   logic            ready;
   logic            touched;
   logic [X_W-1:0]  pos_x;
   logic [Y_W-1:0]  pos_y;
   logic [MS_W-1:0] now_ms;
   logic            front_touched;
   logic            mid_touched;
   logic            back_touched;
   modport source (output valid, touched, pos_x, pos_y, now_ms, front_touched,
                   mid_touched, back_touched, input ready);
   modport sink   (input valid, touched, pos_x, pos_y, now_ms, front_touched,
                   mid_touched, back_touched, output ready);
endinterface

interface tgr_rsp_if;
   logic valid;
   logic ready;
   logic tap;
   logic tap_from_body;
   logic scrub;
   logic hold_start;
   logic hold_end;
   logic swipe_down;
   logic swipe_left;
   logic swipe_right;
   logic cancel_buttons;
   logic button_a;
   logic button_b;
   modport source (output valid, tap, tap_from_body, scrub, hold_start, hold_end,
                   swipe_down, swipe_left, swipe_right, cancel_buttons, button_a,
                   button_b, input ready);
   modport sink   (input valid, tap, tap_from_body, scrub, hold_start, hold_end,
                   swipe_down, swipe_left, swipe_right, cancel_buttons, button_a,
                   button_b, output ready);
endinterface

interface tgr_csr_if;
   import tgr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/touch_gesture_recognizer_core.sv
`timescale 1ns / 1ps
// Top level of the touch gesture recognizer.
//
// Each request is one touch poll and gives exactly one response of event
// pulses and strip button levels. A request is registered on accept, classified
// by the debounce, body-zone and panel units against the gesture state once the
// response register is free, and the response is registered. Throughput is one
// poll per clock while rsp_ready keeps the response moving. The response register
// lets a new poll be accepted while a finished response still waits for rsp_ready.
// Registers are written through the csr channel (always ready); the user must
// write them only while no poll is in flight, the block itself does not enforce it.
module touch_gesture_recognizer_core (
   input  logic       clock,
   input  logic       reset,
   tgr_req_if.sink    req_ch,
   tgr_rsp_if.source  rsp_ch,
   tgr_csr_if.sink    csr_ch
);
   import tgr_pkg::*;

   // Register file
   tgr_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (tgr_csr_idx_type'(csr_ch.index))
            CSR_TAP_MAX_MS:      cfg_in.tap_max_ms      = csr_ch.data;
            CSR_HOLD_MS:         cfg_in.hold_ms         = csr_ch.data;
            CSR_STILL_PX:        cfg_in.still_px        = csr_ch.data[PX_W-1:0];
            CSR_SWIPE_DOWN_PX:   cfg_in.swipe_down_px   = csr_ch.data[PX_W-1:0];
            CSR_SWIPE_SIDE_PX:   cfg_in.swipe_side_px   = csr_ch.data[PX_W-1:0];
            CSR_SCRUB_STEP_PX:   cfg_in.scrub_step_px   = csr_ch.data[PX_W-1:0];
            CSR_SCRUB_REVERSALS: cfg_in.scrub_reversals = csr_ch.data[REV_W-1:0];
            CSR_RELEASE_POLLS:   cfg_in.release_polls   = csr_ch.data[RC_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tap_max_ms      <= TAP_MAX_MS_RST;
         cfg_ff.hold_ms         <= HOLD_MS_RST;
         cfg_ff.still_px        <= STILL_PX_RST;
         cfg_ff.swipe_down_px   <= SWIPE_DOWN_PX_RST;
         cfg_ff.swipe_side_px   <= SWIPE_SIDE_PX_RST;
         cfg_ff.scrub_step_px   <= SCRUB_STEP_PX_RST;
         cfg_ff.scrub_reversals <= SCRUB_REVERSALS_RST;
         cfg_ff.release_polls   <= RELEASE_POLLS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Request register and pipeline control
   tgr_poll_type   poll_ff;
   logic           poll_valid_ff, poll_valid_in;
   logic           rsp_valid_ff, rsp_valid_in;
   tgr_result_type rsp_ff, rsp_in;
   logic           req_fire, work;

   assign work     = poll_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !poll_valid_ff || work;

   assign poll_valid_in = req_fire ? 1'b1 : (work ? 1'b0 : poll_valid_ff);
   assign rsp_valid_in  = work ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         poll_valid_ff <= poll_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         poll_ff.touched       <= req_ch.touched;
         poll_ff.pos_x         <= req_ch.pos_x;
         poll_ff.pos_y         <= req_ch.pos_y;
         poll_ff.now_ms        <= req_ch.now_ms;
         poll_ff.front_touched <= req_ch.front_touched;
         poll_ff.mid_touched   <= req_ch.mid_touched;
         poll_ff.back_touched  <= req_ch.back_touched;
      end
      if (work) begin
         rsp_ff <= rsp_in;
      end
   end

   // Classification units, state advances once per poll
   tgr_touch_type    touch;
   tgr_body_ev_type  body_ev;
   tgr_panel_ev_type panel_ev;
   logic             in_strip;

   tgr_debounce u_debounce (
      .clock         (clock),
      .reset         (reset),
      .step          (work),
      .release_polls (cfg_ff.release_polls),
      .touched       (poll_ff.touched),
      .pos_x         (poll_ff.pos_x),
      .pos_y         (poll_ff.pos_y),
      .touch         (touch)
   );

   tgr_body u_body (
      .clock         (clock),
      .reset         (reset),
      .step          (work),
      .tap_max_ms    (cfg_ff.tap_max_ms),
      .hold_ms       (cfg_ff.hold_ms),
      .now_ms        (poll_ff.now_ms),
      .front_touched (poll_ff.front_touched),
      .mid_touched   (poll_ff.mid_touched),
      .ev            (body_ev)
   );

   // body zones are judged before the panel
   tgr_panel u_panel (
      .clock    (clock),
      .reset    (reset),
      .step     (work),
      .cfg      (cfg_ff),
      .touch    (touch),
      .now_ms   (poll_ff.now_ms),
      .body_tap (body_ev.tap),
      .ev       (panel_ev)
   );

   // Strip buttons follow the debounced contact; button B also follows the back zone
   assign in_strip = touch.down && (32'(touch.good_y) >= 32'(STRIP_TOP));

   always_comb begin
      rsp_in.tap            = panel_ev.tap;
      rsp_in.tap_from_body  = panel_ev.tap_from_body;
      rsp_in.scrub          = panel_ev.scrub;
      rsp_in.hold_start     = panel_ev.hold_start || body_ev.hold_start;
      rsp_in.hold_end       = panel_ev.hold_end || body_ev.hold_end;
      rsp_in.swipe_down     = panel_ev.swipe_down;
      rsp_in.swipe_left     = panel_ev.swipe_left;
      rsp_in.swipe_right    = panel_ev.swipe_right;
      rsp_in.cancel_buttons = panel_ev.cancel_buttons;
      rsp_in.button_a       = in_strip && (32'(touch.good_x) < 32'(SCREEN_WIDTH / 2));
      rsp_in.button_b       = (in_strip && (32'(touch.good_x) >= 32'(SCREEN_WIDTH / 2)))
                              || poll_ff.back_touched;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.tap            = rsp_ff.tap;
   assign rsp_ch.tap_from_body  = rsp_ff.tap_from_body;
   assign rsp_ch.scrub          = rsp_ff.scrub;
   assign rsp_ch.hold_start     = rsp_ff.hold_start;
   assign rsp_ch.hold_end       = rsp_ff.hold_end;
   assign rsp_ch.swipe_down     = rsp_ff.swipe_down;
   assign rsp_ch.swipe_left     = rsp_ff.swipe_left;
   assign rsp_ch.swipe_right    = rsp_ff.swipe_right;
   assign rsp_ch.cancel_buttons = rsp_ff.cancel_buttons;
   assign rsp_ch.button_a       = rsp_ff.button_a;
   assign rsp_ch.button_b       = rsp_ff.button_b;

   // Checks
   a_swipe_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_ff.swipe_down, rsp_ff.swipe_left, rsp_ff.swipe_right}))
      else $error("more than one swipe direction in one response");

   a_swipe_cancels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.swipe_down || rsp_ff.swipe_left || rsp_ff.swipe_right)
      |-> rsp_ff.cancel_buttons && !rsp_ff.scrub)
      else $error("swipe without cancel or together with scrub");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("stalled response lost or changed");

   a_stall_holds_poll: assert property (@(posedge clock) disable iff (reset)
      poll_valid_ff && !work |=> poll_valid_ff && $stable(poll_ff))
      else $error("stalled poll lost or changed");

endmodule

// File: hw/rtl/tgr_debounce.sv
`timescale 1ns / 1ps
// Release-edge debounce of the panel contact and kept coordinates.
module tgr_debounce (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [tgr_pkg::RC_W-1:0]    release_polls,
   input  logic                        touched,
   input  logic [tgr_pkg::X_W-1:0]     pos_x,
   input  logic [tgr_pkg::Y_W-1:0]     pos_y,
   output tgr_pkg::tgr_touch_type      touch
);
   import tgr_pkg::*;

   logic [RC_W-1:0] rc_ff, rc_in;
   logic            held_ff, held_in;
   logic [X_W-1:0]  gx_ff, gx_in;
   logic [Y_W-1:0]  gy_ff, gy_in;
   logic            down;

   always_comb begin
      rc_in = rc_ff;
      down  = touched;
      if (touched) begin
         rc_in = '0;
      end else if (held_ff && (rc_ff < release_polls)) begin
         rc_in = rc_ff + RC_W'(1);
         down  = 1'b1;   // tolerated empty poll
      end
      held_in = down;
      gx_in   = gx_ff;
      gy_in   = gy_ff;
      // coordinates only sampled on a real contact
      if (down && (rc_in == '0)) begin
         gx_in = pos_x;
         gy_in = pos_y;
      end
   end

   assign touch.down   = down;
   assign touch.good_x = gx_in;
   assign touch.good_y = gy_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_ff   <= '0;
         held_ff <= 1'b0;
         gx_ff   <= '0;
         gy_ff   <= '0;
      end else if (step) begin
         rc_ff   <= rc_in;
         held_ff <= held_in;
         gx_ff   <= gx_in;
         gy_ff   <= gy_in;
      end
   end

endmodule

// File: hw/rtl/tgr_body.sv
`timescale 1ns / 1ps
// Body zone taps (front) and holds (middle).
module tgr_body (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [tgr_pkg::TIME_W-1:0]   tap_max_ms,
   input  logic [tgr_pkg::TIME_W-1:0]   hold_ms,
   input  logic [tgr_pkg::MS_W-1:0]     now_ms,
   input  logic                         front_touched,
   input  logic                         mid_touched,
   output tgr_pkg::tgr_body_ev_type     ev
);
   import tgr_pkg::*;

   logic            front_held_ff;
   logic [MS_W-1:0] front_start_ff, front_start_in;
   logic            mid_held_ff;
   logic [MS_W-1:0] mid_start_ff, mid_start_in;
   logic            body_hold_ff, body_hold_in;
   logic [MS_W-1:0] front_age, mid_age;
   logic            front_tap, hold_start_ev, hold_end_ev;

   assign front_age = now_ms - front_start_ff;

   always_comb begin
      front_start_in = front_start_ff;
      front_tap      = 1'b0;
      if (front_touched && !front_held_ff) begin
         front_start_in = now_ms;
      end else if (!front_touched && front_held_ff) begin
         front_tap = (front_age < MS_W'(tap_max_ms));
      end
   end

   assign mid_start_in = (mid_touched && !mid_held_ff) ? now_ms : mid_start_ff;
   assign mid_age      = now_ms - mid_start_in;

   always_comb begin
      body_hold_in  = body_hold_ff;
      hold_start_ev = 1'b0;
      hold_end_ev   = 1'b0;
      if (mid_touched && !body_hold_ff && (mid_age >= MS_W'(hold_ms))) begin
         body_hold_in  = 1'b1;
         hold_start_ev = 1'b1;
      end else if (!mid_touched && body_hold_ff) begin
         body_hold_in = 1'b0;
         hold_end_ev  = 1'b1;
      end
   end

   assign ev = '{tap: front_tap, hold_start: hold_start_ev, hold_end: hold_end_ev};

   always_ff @(posedge clock) begin
      if (reset) begin
         front_held_ff  <= 1'b0;
         front_start_ff <= '0;
         mid_held_ff    <= 1'b0;
         mid_start_ff   <= '0;
         body_hold_ff   <= 1'b0;
      end else if (step) begin
         front_held_ff  <= front_touched;
         front_start_ff <= front_start_in;
         mid_held_ff    <= mid_touched;
         mid_start_ff   <= mid_start_in;
         body_hold_ff   <= body_hold_in;
      end
   end

endmodule

// File: hw/rtl/tgr_panel.sv
`timescale 1ns / 1ps
// Panel press classifier: tap, hold, swipes and scrub.
module tgr_panel (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  tgr_pkg::tgr_cfg_type          cfg,
   input  tgr_pkg::tgr_touch_type        touch,
   input  logic [tgr_pkg::MS_W-1:0]      now_ms,
   input  logic                          body_tap,
   output tgr_pkg::tgr_panel_ev_type     ev
);
   import tgr_pkg::*;

   logic               active_ff, active_in;
   logic [MS_W-1:0]    start_ms_ff, start_ms_in;
   logic [X_W-1:0]     start_x_ff, start_x_in;
   logic [Y_W-1:0]     start_y_ff, start_y_in;
   logic [X_W-1:0]     anchor_ff, anchor_in;
   tgr_dir_type        dir_ff, dir_in, step_dir;
   logic [REV_W-1:0]   rev_ff, rev_in;
   logic               swl_ff, swl_in;
   logic               hold_ff, hold_in;
   logic               ltb_ff, ltb_in;

   logic signed [X_W:0] dx, sx;
   logic signed [Y_W:0] dy;
   logic [X_W:0]        dx_neg, sx_neg;
   logic [Y_W:0]        dy_neg;
   logic [X_W-1:0]      dx_mag, sx_mag;
   logic [Y_W-1:0]      dy_mag;
   logic [MS_W-1:0]     age;
   logic                still, is_tap, is_down, is_side;

   assign dx     = $signed({1'b0, touch.good_x}) - $signed({1'b0, start_x_ff});
   assign dy     = $signed({1'b0, touch.good_y}) - $signed({1'b0, start_y_ff});
   assign sx     = $signed({1'b0, touch.good_x}) - $signed({1'b0, anchor_ff});
   assign dx_neg = -dx;
   assign dy_neg = -dy;
   assign sx_neg = -sx;
   assign dx_mag = dx[X_W] ? dx_neg[X_W-1:0] : dx[X_W-1:0];
   assign dy_mag = dy[Y_W] ? dy_neg[Y_W-1:0] : dy[Y_W-1:0];
   assign sx_mag = sx[X_W] ? sx_neg[X_W-1:0] : sx[X_W-1:0];
   assign age    = now_ms - start_ms_ff;

   assign still   = (dx_mag < cfg.still_px) && ({1'b0, dy_mag} < cfg.still_px);
   assign is_tap  = (age < MS_W'(cfg.tap_max_ms)) && still;
   assign is_down = !dy[Y_W] && ({1'b0, dy_mag} > cfg.swipe_down_px)
                    && ({2'b0, dy_mag} > {dx_mag, 1'b0});
   assign is_side = (dx_mag > cfg.swipe_side_px)
                    && ({1'b0, dx_mag} > {1'b0, dy_mag, 1'b0});
   assign step_dir = sx[X_W] ? DIR_LEFT : DIR_RIGHT;

   always_comb begin
      active_in   = active_ff;
      start_ms_in = start_ms_ff;
      start_x_in  = start_x_ff;
      start_y_in  = start_y_ff;
      anchor_in   = anchor_ff;
      dir_in      = dir_ff;
      rev_in      = rev_ff;
      swl_in      = swl_ff;
      hold_in     = hold_ff;
      ltb_in      = body_tap ? 1'b1 : ltb_ff;
      ev          = '0;
      ev.tap      = body_tap;

      if (touch.down && !active_ff) begin
         active_in   = 1'b1;
         start_ms_in = now_ms;
         start_x_in  = touch.good_x;
         start_y_in  = touch.good_y;
         anchor_in   = touch.good_x;
         dir_in      = DIR_NONE;
         rev_in      = '0;
         swl_in      = 1'b0;
      end else if (touch.down && active_ff) begin
         if (!hold_ff && (age >= MS_W'(cfg.hold_ms)) && still) begin
            hold_in           = 1'b1;
            ev.hold_start     = 1'b1;
            ev.cancel_buttons = 1'b1;
         end
         if (!hold_in) begin
            if (!swl_in && is_down) begin
               ev.swipe_down     = 1'b1;
               swl_in            = 1'b1;
               rev_in            = '0;
               ev.cancel_buttons = 1'b1;
            end
            if (!swl_in && is_side) begin
               ev.swipe_right    = !dx[X_W];
               ev.swipe_left     = dx[X_W];
               swl_in            = 1'b1;
               rev_in            = '0;
               ev.cancel_buttons = 1'b1;
            end
            if (!swl_in) begin
               if (sx_mag > cfg.scrub_step_px) begin
                  if ((dir_ff != DIR_NONE) && (step_dir != dir_ff) && (rev_ff < REV_MAX)) begin
                     rev_in = rev_ff + REV_W'(1);
                  end
                  dir_in    = step_dir;
                  anchor_in = touch.good_x;
               end
               // scrub ends the press, finger may stay down
               if (rev_in >= cfg.scrub_reversals) begin
                  ev.scrub  = 1'b1;
                  active_in = 1'b0;
               end
            end
         end
      end else if (!touch.down && active_ff) begin
         active_in = 1'b0;
         if (hold_ff) begin
            hold_in     = 1'b0;
            ev.hold_end = 1'b1;
         end else if (!swl_ff && is_tap) begin
            ev.tap = 1'b1;
            ltb_in = 1'b0;
         end
      end
      ev.tap_from_body = ltb_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         start_ms_ff <= '0;
         start_x_ff  <= '0;
         start_y_ff  <= '0;
         anchor_ff   <= '0;
         dir_ff      <= DIR_NONE;
         rev_ff      <= '0;
         swl_ff      <= 1'b0;
         hold_ff     <= 1'b0;
         ltb_ff      <= 1'b0;
      end else if (step) begin
         active_ff   <= active_in;
         start_ms_ff <= start_ms_in;
         start_x_ff  <= start_x_in;
         start_y_ff  <= start_y_in;
         anchor_ff   <= anchor_in;
         dir_ff      <= dir_in;
         rev_ff      <= rev_in;
         swl_ff      <= swl_in;
         hold_ff     <= hold_in;
         ltb_ff      <= ltb_in;
      end
   end

endmodule
